// ===== design/pvd_pkg.sv =====
// package: field widths and constants for the packed volume decoder
`default_nettype none
package pvd_pkg;
  localparam int unsigned RawW = 32;
  localparam int unsigned OutW = 64;
  localparam int unsigned MantW = 26;
  localparam int unsigned ExpW = 11;
  localparam int unsigned FracW = 52;
  localparam logic [7:0] HSplit = 8'h80;
  localparam logic [ExpW-1:0] ExpBias = 11'd1023;
  localparam logic [ExpW-1:0] ExpOff = 11'd127;
  typedef logic [RawW-1:0] raw_t;
  typedef logic [OutW-1:0] bits_t;
endpackage
`default_nettype wire

// ===== design/pvd_if.sv =====
// interfaces: valid/ready channels for raw words and double patterns
`default_nettype none
interface pvd_raw_if;
  logic valid;
  logic ready;
  pvd_pkg::raw_t raw_word;
  modport source (output valid, output raw_word, input ready);
  modport sink (input valid, input raw_word, output ready);
endinterface

interface pvd_out_if;
  logic valid;
  logic ready;
  pvd_pkg::bits_t volume_bits;
  modport source (output valid, output volume_bits, input ready);
  modport sink (input valid, input volume_bits, output ready);
endinterface
`default_nettype wire

// ===== design/packed_volume_to_double.sv =====
// top level: packed volume word to binary64 bit pattern, three-stage pipeline
`default_nettype none
// Converts one packed 32-bit volume word per cycle into the bit pattern of a
// positive IEEE-754 double. An item passes through three register stages, and
// the result is valid once it reaches stage three, where it waits to be taken.
// Throughput is one item per cycle while the output side takes items.
// Stage one splits the word and forms the biased exponent base and the
// mantissa terms, stage two adds the mantissa, stage three finds the leading
// one (bit 23, 24 or 25) and packs exponent and fraction. A stall on the
// output freezes all stages that hold an item; a stage with a bubble keeps
// filling, so nothing is lost or repeated.
module packed_volume_to_double (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pvd_raw_if.sink   in_i,
  pvd_out_if.source out_o
);
  import pvd_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  // stage 1 payload
  logic [ExpW-1:0] eb1_q;
  logic [MantW-1:0] t1_q, low1_q;
  // stage 2 payload
  logic [ExpW-1:0] eb2_q;
  logic [MantW-1:0] m2_q;
  // stage 3 payload
  bits_t out_q;

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // stage 1 decode
  logic [7:0] lbyte, hb;
  logic [ExpW-1:0] eb1_d;
  logic [MantW-1:0] t1_d, low1_d;
  always_comb begin
    lbyte = in_i.raw_word[31:24];
    hb = in_i.raw_word[23:16];
    // biased exponent for leading one at bit 23: 2L - 127 + 1023, mod 2^11
    eb1_d = {{2{lbyte[7]}}, lbyte, 1'b0} - ExpOff + ExpBias;
    if (hb > HSplit) begin
      t1_d = MantW'({7'd64 + {1'b0, hb[6:0]}, 17'd0});
    end else begin
      t1_d = MantW'({hb, 16'd0});
    end
    t1_d = t1_d + MantW'(24'h800000);
    if (hb[7]) begin
      low1_d = MantW'({in_i.raw_word[15:0], 1'b0});
    end else begin
      low1_d = MantW'(in_i.raw_word[15:0]);
    end
  end

  // stage 3 normalize and pack
  logic [ExpW-1:0] eb3;
  logic [FracW-1:0] frac3;
  always_comb begin
    priority if (m2_q[25]) begin
      eb3 = eb2_q + 11'd2;
      frac3 = {m2_q[24:0], 27'd0};
    end else if (m2_q[24]) begin
      eb3 = eb2_q + 11'd1;
      frac3 = {m2_q[23:0], 28'd0};
    end else begin
      eb3 = eb2_q;
      frac3 = {m2_q[22:0], 29'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      eb1_q <= eb1_d;
      t1_q <= t1_d;
      low1_q <= low1_d;
    end
    if (en2) begin
      eb2_q <= eb1_q;
      m2_q <= t1_q + low1_q;
    end
    if (en3) out_q <= {1'b0, eb3, frac3};
  end

  assign out_o.valid = v3_q;
  assign out_o.volume_bits = out_q;

  // mantissa always has its leading one at bit 23..25
  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (m2_q[25:23] != 3'b000)) else $error("mantissa out of range");
  // sign bit is always clear on a valid result
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> !out_q[63]) else $error("negative result");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_o.ready |=> v3_q && $stable(out_q)) else $error("result lost");
endmodule
`default_nettype wire

// ===== bench/tb_packed_volume_to_double.sv =====
// testbench: packed volume decoder checked against its own bit-exact predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_packed_volume_to_double;
  import pvd_pkg::*;

  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned DrainCycles = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pvd_raw_if raw_ch ();
  pvd_out_if out_ch ();

  packed_volume_to_double i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (raw_ch.sink),
    .out_o (out_ch.source)
  );

  always #1 clk_i = ~clk_i;

  // pending expected double patterns, oldest first
  bits_t volume_q[$];
  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  // idle odds in percent for sender and receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // predicts the double pattern for one packed word
  function automatic bits_t decode_volume(raw_t w);
    logic [7:0] lbyte, hb;
    logic [63:0] mant, low;
    int l, e, p, bexp;
    logic [63:0] frac;
    lbyte = w[31:24];
    hb = w[23:16];
    low = {48'd0, w[15:0]};
    l = $signed(lbyte);
    e = 2 * l - 127;
    mant = 64'd1 << 23;
    // above the split the second byte steps in units of 2^17
    if (hb > HSplit) mant += (64'd64 + {57'd0, hb[6:0]}) << 17;
    else mant += {56'd0, hb} << 16;
    // top bit of the second byte doubles the low half
    if (hb[7]) low = low << 1;
    mant += low;
    p = 23;
    while (p < 25 && (mant >> (p + 1)) != 0) p++;
    bexp = e - 23 + p + 1023;
    frac = (mant << (52 - p)) & ((64'd1 << 52) - 1);
    return {1'b0, bexp[10:0], frac[51:0]};
  endfunction

  // receiver: random stalls and compare against oldest expectation
  always @(posedge clk_i) begin
    bits_t exp_bits;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (volume_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time,
                   out_ch.volume_bits);
          fail_cnt++;
        end else begin
          exp_bits = volume_q.pop_front();
          if (out_ch.volume_bits !== exp_bits) begin
            $display("%0t: volume_bits expected %h actual %h", $time, exp_bits,
                     out_ch.volume_bits);
            fail_cnt++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  // watchdog: cycles with no item accepted on either side
  always @(posedge clk_i) begin
    if ((raw_ch.valid && raw_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (rst_ni && (raw_ch.valid || volume_q.size() != 0))
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sends one item, with random idle cycles first; valid stays high after
  // acceptance so back-to-back items see one assignment per edge
  task automatic send_word(raw_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      raw_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    raw_ch.valid <= 1'b1;
    raw_ch.raw_word <= w;
    volume_q = {volume_q, decode_volume(w)};
    @(posedge clk_i);
    while (!raw_ch.ready) @(posedge clk_i);
  endtask

  // exponent byte extremes, second byte around the split, low bytes extremes
  task automatic test_directed();
    raw_t words[$];
    words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7F00_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h80FF_FFFF, 32'h0080_0000, 32'h0080_FFFF,
              32'h0081_0000, 32'h0081_FFFF, 32'h007F_FFFF, 32'h007F_0000,
              32'h00FF_0000, 32'h0001_0001, 32'h3F80_8080, 32'hC07F_8001,
              32'h40C0_FFFF, 32'h0040_0000, 32'h0000_FFFF, 32'h0000_0001,
              32'hAA55_AA55, 32'h55AA_55AA};
    foreach (words[i]) send_word(words[i]);
  endtask

  // random words, second byte often near the split
  task automatic test_random(int unsigned n);
    raw_t w;
    repeat (n) begin
      w = $urandom;
      if ($urandom_range(3) == 0) w[23:16] = 8'h7E + 8'($urandom_range(4));
      send_word(w);
    end
  endtask

  task automatic wait_drain();
    raw_ch.valid <= 1'b0;
    while (volume_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    raw_ch.valid <= 1'b0;
    raw_ch.raw_word <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 16;
    recv_idle_pct = 53;
    test_directed();
    test_random(550);
    send_idle_pct = 53;
    recv_idle_pct = 16;
    test_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(550);
    wait_drain();
    if (fail_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ===== packed_volume_to_double.f =====
design/pvd_pkg.sv
design/pvd_if.sv
design/packed_volume_to_double.sv
bench/tb_packed_volume_to_double.sv
